### src/stq_pkg.sv
// shared types and constants for the sorted timer expiry queue
`default_nettype none
package stq_pkg;

	localparam int ID_W = 4;
	localparam int NS_W = 64;
	localparam int PERIOD_W = 30;
	localparam int TICKS_W = 8;
	localparam int ADV_W = 32;
	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 30'd10000000;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_ARM  = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		LOP_NOP,
		LOP_INSERT,
		LOP_POP_HEAD,
		LOP_REMOVE
	} list_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ARM_WR,
		S_INS_RD,
		S_INS_CMP,
		S_TICK_ADD,
		S_FIRE_RD,
		S_FIRE_CHK,
		S_FIRE_END,
		S_RE_RD,
		S_RE_ID,
		S_RE_KEY
	} state_t;

endpackage
`default_nettype wire

### src/stq_ram.sv
// simple dual-port memory, one write and one registered read per cycle
`default_nettype none
module stq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/stq_order_list.sv
// slot list in expiry order with insert, head pop and removal by slot
`default_nettype none
module stq_order_list #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire stq_pkg::list_op_t               op,
	input  wire logic [$clog2(NUM_TIMERS+1)-1:0] pos,
	input  wire logic [$clog2(NUM_TIMERS)-1:0]   id,
	input  wire logic [$clog2(NUM_TIMERS)-1:0]   rd_pos,
	output logic      [$clog2(NUM_TIMERS)-1:0]   rd_id,
	output logic      [$clog2(NUM_TIMERS)-1:0]   head,
	output logic      [$clog2(NUM_TIMERS+1)-1:0] count
);
	import stq_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS+1);

	logic [IW-1:0] ent_q [NUM_TIMERS];
	logic [CW-1:0] count_q;
	logic [NUM_TIMERS-1:0] match;
	logic [NUM_TIMERS-1:0] at_or_after;

	assign rd_id = ent_q[rd_pos];
	assign head  = ent_q[0];
	assign count = count_q;

	always_comb begin
		for (int j = 0; j < NUM_TIMERS; j++) begin
			match[j] = (ent_q[j] == id) && (CW'(j) < count_q);
		end
		at_or_after[0] = match[0];
		for (int j = 1; j < NUM_TIMERS; j++) begin
			at_or_after[j] = at_or_after[j-1] | match[j];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			LOP_INSERT: begin
				for (int j = 0; j < NUM_TIMERS; j++) begin
					if (CW'(j) == pos) begin
						ent_q[j] <= id;
					end else if (CW'(j) > pos && j > 0) begin
						ent_q[j] <= ent_q[(j > 0) ? j-1 : 0];
					end
				end
			end
			LOP_POP_HEAD: begin
				for (int j = 0; j + 1 < NUM_TIMERS; j++) begin
					ent_q[j] <= ent_q[j+1];
				end
			end
			LOP_REMOVE: begin
				for (int j = 0; j + 1 < NUM_TIMERS; j++) begin
					if (at_or_after[j]) begin
						ent_q[j] <= ent_q[j+1];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				LOP_INSERT:   count_q <= count_q + CW'(1);
				LOP_POP_HEAD: count_q <= count_q - CW'(1);
				LOP_REMOVE: begin
					if (|match) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/sorted_timer_expiry_queue_unit.sv
// stop removes the slot from the list as its word is accepted; arm writes the expiry, then walks the list
// past entries expiring no later; tick advances time, pops each expired head, marks the last fired output
// as last, then re-inserts each periodic timer that fired; a full output register stalls the expiry scan
// the insert walk and expiry scan share one read port of the expiry memory
// one item in flight at a time; a result register lets the next result wait on the output
// reset clears time, active flags and list length; period returns to 10 ms, no clearing pass
`default_nettype none
module sorted_timer_expiry_queue_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [29:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// timer_id[3:0], delay_ns[67:4], interval_ns[131:68], elapsed_ticks[139:132]
	input  wire logic [143:0] s_axis_tdata,
	// action[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// fired_id[3:0]
	output logic [7:0]        m_axis_tdata,
	// fired_periodic[0]
	output logic [0:0]        m_axis_tuser,
	output logic              m_axis_tlast
);
	import stq_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS+1);

	state_t state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [NS_W-1:0] now_q, sum_q, key_q, delay_q, interval_q;
	logic [PERIOD_W+TICKS_W-1:0] prod_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [IW-1:0] ins_id_q, pend_id_q;
	logic [CW-1:0] pos_q, nf_q, k_q;
	logic ret_q, pend_v_q, pend_per_q;
	logic out_v_q, out_per_q, out_last_q;
	logic [IW-1:0] out_id_q;

	logic accept, out_free, id_ok, periodic_c;
	action_t in_act;
	logic [ID_W-1:0] in_id;
	logic [IW-1:0] in_slot;
	logic [NS_W-1:0] key_c;

	list_op_t lop;
	logic [IW-1:0] l_id, l_rd_id, l_head;
	logic [CW-1:0] l_count;

	logic [IW-1:0] raddr, ewaddr;
	logic ewe, fwe, out_load, out_last_c;
	logic [NS_W-1:0] ewdata, exp_rd, rel_rd;
	logic [IW-1:0] fm_rd;

	assign cfg_ready = 1'b1;
	assign in_act = action_t'(s_axis_tuser);
	assign in_id = s_axis_tdata[3:0];
	assign in_slot = IW'(in_id);
	assign id_ok = 32'(in_id) < NUM_TIMERS;
	assign accept = s_axis_tvalid & s_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;
	// a delay of one means the next tick only
	assign key_c = sum_q + ((delay_q == 64'd1) ? '0 : delay_q);
	assign periodic_c = rel_rd != '0;
	// removal on an incoming word uses its slot straight from the bus
	assign l_id = (state_q == S_IDLE) ? in_slot : ins_id_q;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'b0, 4'(out_id_q)};
	assign m_axis_tuser = out_per_q;
	assign m_axis_tlast = out_last_q;

	stq_order_list #(.NUM_TIMERS(NUM_TIMERS)) u_list (
		.clk, .arst_n, .op(lop), .pos(pos_q), .id(l_id),
		.rd_pos(pos_q[IW-1:0]), .rd_id(l_rd_id), .head(l_head), .count(l_count)
	);

	stq_ram #(.WIDTH(NS_W), .DEPTH(NUM_TIMERS)) u_expire (
		.clk, .we(ewe), .waddr(ewaddr), .wdata(ewdata), .raddr(raddr), .rdata(exp_rd)
	);

	stq_ram #(.WIDTH(NS_W), .DEPTH(NUM_TIMERS)) u_reload (
		.clk, .we(state_q == S_ARM_WR), .waddr(ins_id_q), .wdata(interval_q),
		.raddr(raddr), .rdata(rel_rd)
	);

	// periodic timers that fired on this tick, in firing order
	stq_ram #(.WIDTH(IW), .DEPTH(NUM_TIMERS)) u_fired (
		.clk, .we(fwe), .waddr(nf_q[IW-1:0]), .wdata(l_head),
		.raddr(k_q[IW-1:0]), .rdata(fm_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		lop = LOP_NOP;
		raddr = l_head;
		ewe = 1'b0;
		ewaddr = ins_id_q;
		ewdata = key_c;
		fwe = 1'b0;
		out_load = 1'b0;
		out_last_c = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept) begin
					case (in_act)
						ACT_ARM: begin
							if (id_ok) begin
								if (active_q[in_slot]) begin
									lop = LOP_REMOVE;
								end
								state_d = S_ARM_WR;
							end
						end
						ACT_STOP: begin
							if (id_ok && active_q[in_slot]) begin
								lop = LOP_REMOVE;
							end
						end
						ACT_TICK: state_d = S_TICK_ADD;
						default: ;
					endcase
				end
			end
			S_ARM_WR: begin
				ewe = 1'b1;
				state_d = S_INS_RD;
			end
			S_INS_RD: begin
				if (pos_q == l_count) begin
					lop = LOP_INSERT;
					state_d = ret_q ? S_RE_RD : S_IDLE;
				end else begin
					raddr = l_rd_id;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// equal expiry goes behind, keeping arming order
				if (exp_rd <= key_q) begin
					state_d = S_INS_RD;
				end else begin
					lop = LOP_INSERT;
					state_d = ret_q ? S_RE_RD : S_IDLE;
				end
			end
			S_TICK_ADD: state_d = S_FIRE_RD;
			S_FIRE_RD: begin
				state_d = (l_count == '0) ? S_FIRE_END : S_FIRE_CHK;
			end
			S_FIRE_CHK: begin
				if (exp_rd <= now_q) begin
					if (!pend_v_q || out_free) begin
						lop = LOP_POP_HEAD;
						ewe = periodic_c;
						ewaddr = l_head;
						ewdata = exp_rd + rel_rd;
						fwe = periodic_c;
						out_load = pend_v_q;
						state_d = S_FIRE_RD;
					end
				end else begin
					state_d = S_FIRE_END;
				end
			end
			S_FIRE_END: begin
				if (!pend_v_q || out_free) begin
					out_load = pend_v_q;
					out_last_c = 1'b1;
					state_d = S_RE_RD;
				end
			end
			S_RE_RD: begin
				state_d = (k_q == nf_q) ? S_IDLE : S_RE_ID;
			end
			S_RE_ID: begin
				raddr = fm_rd;
				state_d = S_RE_KEY;
			end
			S_RE_KEY: state_d = S_INS_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			ins_id_q <= in_slot;
			delay_q <= s_axis_tdata[67:4];
			interval_q <= s_axis_tdata[131:68];
			sum_q <= now_q + NS_W'(period_q);
			prod_q <= s_axis_tdata[139:132] * period_q;
		end
		case (state_q)
			S_ARM_WR: begin
				key_q <= key_c;
				pos_q <= '0;
			end
			S_INS_CMP: begin
				if (exp_rd <= key_q) begin
					pos_q <= pos_q + CW'(1);
				end
			end
			S_FIRE_CHK: begin
				if (lop == LOP_POP_HEAD) begin
					pend_id_q <= l_head;
					pend_per_q <= periodic_c;
				end
			end
			S_RE_ID: ins_id_q <= fm_rd;
			S_RE_KEY: begin
				key_q <= exp_rd;
				pos_q <= '0;
			end
			default: ;
		endcase
		if (out_load) begin
			out_id_q <= pend_id_q;
			out_per_q <= pend_per_q;
			out_last_q <= out_last_c;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= TICK_PERIOD_RESET;
			now_q <= '0;
			active_q <= '0;
			ret_q <= 1'b0;
			nf_q <= '0;
			k_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			if (state_q == S_IDLE && accept && id_ok) begin
				if (in_act == ACT_ARM) begin
					active_q[in_slot] <= 1'b1;
				end else if (in_act == ACT_STOP) begin
					active_q[in_slot] <= 1'b0;
				end
			end
			if (state_q == S_IDLE && accept) begin
				ret_q <= in_act == ACT_TICK;
			end
			case (state_q)
				S_TICK_ADD: begin
					now_q <= now_q + NS_W'(prod_q[ADV_W-1:0]);
					nf_q <= '0;
					k_q <= '0;
					pend_v_q <= 1'b0;
				end
				S_FIRE_CHK: begin
					if (lop == LOP_POP_HEAD) begin
						pend_v_q <= 1'b1;
						if (periodic_c) begin
							nf_q <= nf_q + CW'(1);
						end else begin
							active_q[l_head] <= 1'b0;
						end
					end
				end
				S_FIRE_END: begin
					if (state_d == S_RE_RD) begin
						pend_v_q <= 1'b0;
					end
				end
				S_RE_RD: begin
					if (k_q != nf_q) begin
						k_q <= k_q + CW'(1);
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
